// ----- rtl/core/square_matrix_product_transpose_top_assert.svh -----
// ----------------------------------------------------------------------------
// square_matrix_product_transpose_top_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_PRODUCT_TRANSPOSE_TOP_ASSERT_SVH
`define SQUARE_MATRIX_PRODUCT_TRANSPOSE_TOP_ASSERT_SVH

// same-cycle implication
`define SMPT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/smpt_pkg.sv -----
// ----------------------------------------------------------------------------
// smpt_pkg
// types and constants of the square matrix product block
// ----------------------------------------------------------------------------
package smpt_pkg;

  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int FRAC_BITS = 28;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_SECOND = 2'd1;

  localparam logic signed [ELEM_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [ELEM_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [ELEM_W-1:0] b_element;
    logic signed [ELEM_W-1:0] c_element;
  } operands_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] product_element;
    logic                     last_result;
  } result_t;

  // one loaded matrix pair waiting for the multiply engine
  typedef struct packed {
    logic bank;
    logic transpose_first;
    logic transpose_second;
  } job_t;

endpackage

// ----- rtl/core/square_matrix_product_transpose_top.sv -----
// ----------------------------------------------------------------------------
// square_matrix_product_transpose_top
// dense DIM x DIM product op(B) * op(C) in signed q4.28
// ----------------------------------------------------------------------------
// One element of B and one of C are taken per transaction, row-major. The
// transaction that completes a matrix pair queues it for the multiply
// engine, which steps through every i, j and k with one shared 32x32
// multiplier, one multiply-accumulate at a time. The DIM*DIM results come
// out on done, the final one with last_result set. The element stores
// hold two banks, so the next pair loads while the engine works; busy is
// high while the job queue holds two loaded pairs. Results cannot be held
// off: the receiver must take each one in the cycle done is high. No
// clearing pass after reset. Config writes take effect for the pair
// completed after them.
// ----------------------------------------------------------------------------
module square_matrix_product_transpose_top #(
  parameter int DIM = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  smpt_pkg::operands_t            operands,
  output logic                           done,
  output smpt_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [smpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);

  localparam int EA    = $clog2(DIM * DIM);
  localparam int DEPTH = 2 * (1 << EA);

  logic           ld_we;
  logic [EA:0]    ld_addr;
  logic           push;
  smpt_pkg::job_t push_job;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  smpt_pkg::job_t head;
  logic [EA:0]    b_addr, c_addr;
  logic signed [smpt_pkg::ELEM_W-1:0] b_data, c_data;

  smpt_front #(.DIM(DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .q_full    (q_full),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .busy      (busy),
    .ld_we     (ld_we),
    .ld_addr   (ld_addr),
    .push      (push),
    .push_job  (push_job)
  );

  smpt_ram #(.WIDTH(smpt_pkg::ELEM_W), .DEPTH(DEPTH)) u_first_store (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_addr),
    .wdata (operands.b_element),
    .raddr (b_addr),
    .rdata (b_data)
  );

  smpt_ram #(.WIDTH(smpt_pkg::ELEM_W), .DEPTH(DEPTH)) u_second_store (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_addr),
    .wdata (operands.c_element),
    .raddr (c_addr),
    .rdata (c_data)
  );

  smpt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  smpt_back #(.DIM(DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (~q_empty),
    .job       (head),
    .pop       (pop),
    .b_addr    (b_addr),
    .c_addr    (c_addr),
    .b_data    (b_data),
    .c_data    (c_data),
    .done      (done),
    .result    (result)
  );

endmodule

// ----- rtl/core/smpt_ram.sv -----
// ----------------------------------------------------------------------------
// smpt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module smpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/smpt_front.sv -----
// ----------------------------------------------------------------------------
// smpt_front
// load side: config registers, element counter, bank select, job push
// ----------------------------------------------------------------------------
module smpt_front #(
  parameter int DIM  = 3,
  localparam int EA  = $clog2(DIM * DIM)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             q_full,
  input  logic                             cfg_valid,
  input  logic [smpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                             cfg_data,
  output logic                             cfg_ready,
  output logic                             busy,
  output logic                             ld_we,
  output logic [EA:0]                      ld_addr,
  output logic                             push,
  output smpt_pkg::job_t                   push_job
);

  localparam logic [EA-1:0] LAST_SLOT = EA'(DIM * DIM - 1);

  logic          transpose_first;
  logic          transpose_second;
  logic [EA-1:0] load_count;
  logic          wbank;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start & ~q_full;
  assign ld_we     = accept;
  assign ld_addr   = {wbank, load_count};
  assign push      = accept && (load_count == LAST_SLOT);

  assign push_job.bank             = wbank;
  assign push_job.transpose_first  = transpose_first;
  assign push_job.transpose_second = transpose_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_first  <= 1'b0;
      transpose_second <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        smpt_pkg::REG_TRANSPOSE_FIRST:  transpose_first  <= cfg_data;
        smpt_pkg::REG_TRANSPOSE_SECOND: transpose_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // banks alternate so the next pair loads while the engine works
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      wbank      <= 1'b0;
    end else if (accept) begin
      if (load_count == LAST_SLOT) begin
        load_count <= '0;
        wbank      <= ~wbank;
      end else begin
        load_count <= load_count + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/smpt_queue.sv -----
// ----------------------------------------------------------------------------
// smpt_queue
// two-entry job queue between load side and multiply engine
// ----------------------------------------------------------------------------
module smpt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  smpt_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output smpt_pkg::job_t head
);

  smpt_pkg::job_t entry [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/smpt_back.sv -----
// ----------------------------------------------------------------------------
// smpt_back
// multiply engine: i/j/k sequencer, shared multiplier, accumulator, rounding
// ----------------------------------------------------------------------------
module smpt_back #(
  parameter int DIM    = 3,
  localparam int EA    = $clog2(DIM * DIM),
  localparam int CW    = $clog2(DIM),
  localparam int ACC_W = smpt_pkg::PROD_W + $clog2(DIM)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  input  smpt_pkg::job_t                      job,
  output logic                                pop,
  output logic [EA:0]                         b_addr,
  output logic [EA:0]                         c_addr,
  input  logic signed [smpt_pkg::ELEM_W-1:0]  b_data,
  input  logic signed [smpt_pkg::ELEM_W-1:0]  c_data,
  output logic                                done,
  output smpt_pkg::result_t                   result
);

  localparam int FB = smpt_pkg::FRAC_BITS;
  localparam logic [CW-1:0] IDX_MAX = CW'(DIM - 1);
  localparam logic [EA-1:0] DIM_E   = EA'(DIM);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FB - 1);

  logic [CW-1:0] i_cnt, j_cnt, k_cnt;
  logic          k_max, j_max, i_max;
  logic [EA-1:0] b_elem, c_elem;

  logic                                  v1, first1, last1, fin1;
  logic                                  v2, first2, last2, fin2;
  logic signed [smpt_pkg::PROD_W-1:0]    prod2;
  logic signed [ACC_W-1:0]               acc;
  logic                                  v3, fin3;
  logic signed [ACC_W-1:0]               rnd;
  logic                                  ovf;
  logic signed [smpt_pkg::ELEM_W-1:0]    sat_val;

  assign k_max = (k_cnt == IDX_MAX);
  assign j_max = (j_cnt == IDX_MAX);
  assign i_max = (i_cnt == IDX_MAX);
  assign pop   = job_valid & k_max & j_max & i_max;

  always_comb begin
    if (job.transpose_first) begin
      b_elem = EA'(k_cnt) * DIM_E + EA'(i_cnt);
    end else begin
      b_elem = EA'(i_cnt) * DIM_E + EA'(k_cnt);
    end
    if (job.transpose_second) begin
      c_elem = EA'(j_cnt) * DIM_E + EA'(k_cnt);
    end else begin
      c_elem = EA'(k_cnt) * DIM_E + EA'(j_cnt);
    end
  end

  assign b_addr = {job.bank, b_elem};
  assign c_addr = {job.bank, c_elem};

  // k innermost, then j, then i: one multiply-accumulate per cycle while a job is queued
  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else if (job_valid) begin
      if (k_max) begin
        k_cnt <= '0;
        if (j_max) begin
          j_cnt <= '0;
          i_cnt <= i_max ? '0 : i_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end else begin
        k_cnt <= k_cnt + 1'b1;
      end
    end
  end

  // round half up, then clamp to the q4.28 range
  always_comb begin
    rnd = acc + HALF;
    ovf = !((&rnd[ACC_W-1:FB+31]) || !(|rnd[ACC_W-1:FB+31]));
    if (ovf) begin
      sat_val = rnd[ACC_W-1] ? smpt_pkg::SAT_MIN : smpt_pkg::SAT_MAX;
    end else begin
      sat_val = rnd[FB+31:FB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      fin3 <= 1'b0;
      done <= 1'b0;
      result <= '0;
    end else begin
      v1   <= job_valid;
      v2   <= v1;
      v3   <= v2 & last2;
      fin3 <= v2 & fin2;
      done <= v3;
      result.last_result     <= v3 & fin3;
      result.product_element <= sat_val;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= (k_cnt == '0);
    last1  <= k_max;
    fin1   <= k_max & j_max & i_max;
    first2 <= first1;
    last2  <= last1;
    fin2   <= fin1;
    prod2  <= b_data * c_data;
    if (v2) begin
      acc <= first2 ? ACC_W'(prod2) : acc + ACC_W'(prod2);
    end
  end

endmodule

// ----- rtl/core/smpt_checker.sv -----
// ----------------------------------------------------------------------------
// smpt_checker
// port-level checks on the matrix product block, bound to the top level
// ----------------------------------------------------------------------------
`include "square_matrix_product_transpose_top_assert.svh"

module smpt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input smpt_pkg::result_t              result
);

  `SMPT_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !done && !busy, "output active after reset")

  `SMPT_ASSERT_IMP(a_last_needs_done, clk, rst, result.last_result, done, "last_result without done")

  `SMPT_ASSERT_NEXT(a_last_isolated, clk, rst, done && result.last_result, !result.last_result, "two last results in a row")

  `SMPT_ASSERT_IMP(a_busy_after_load, clk, rst, $rose(busy), $past(start), "busy rose without a transaction")

endmodule

bind square_matrix_product_transpose_top smpt_checker u_smpt_checker (.*);
